FILE: rtl/core/sas_pkg.sv
`timescale 1ns / 1ps

package sas_pkg;

  // default sizing
  localparam int CAPACITY_DEFAULT  = 64;
  localparam int KEY_WIDTH_DEFAULT = 32;

  // field widths of the item and the result
  localparam int KIND_W  = 2;
  localparam int KEY_W   = 32;
  localparam int FIELD_W = 7;

  // request codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic               was_present;
    logic [FIELD_W-1:0] position;
    logic [FIELD_W-1:0] count_after;
    logic               rejected_full;
  } rsp_t;

  // shift command broadcast to the row of cells
  typedef struct packed {
    logic ins;
    logic del;
  } shift_ctrl_t;

endpackage

FILE: rtl/core/sas_cell.sv
`timescale 1ns / 1ps

module sas_cell #(
  parameter int KEY_WIDTH   = sas_pkg::KEY_WIDTH_DEFAULT,
  parameter int COUNT_WIDTH = 7,
  parameter int INDEX       = 0
) (
  input  logic                        clk,
  input  logic                        cmp_en,
  input  logic signed [KEY_WIDTH-1:0] key,
  input  logic [COUNT_WIDTH-1:0]      count,
  input  logic signed [KEY_WIDTH-1:0] left_key,
  input  logic signed [KEY_WIDTH-1:0] right_key,
  input  logic                        left_lt,
  input  sas_pkg::shift_ctrl_t        ctrl,
  output logic signed [KEY_WIDTH-1:0] stored,
  output logic                        lt,
  output logic                        eq
);

  logic occupied;

  assign occupied = count > COUNT_WIDTH'(INDEX);

  // compare the held key against the broadcast key
  always_ff @(posedge clk) begin
    if (cmp_en) begin
      lt <= occupied && (stored < key);
      eq <= occupied && (stored == key);
    end
  end

  // shift right on insert above the gap, shift left on delete from the hole
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (!left_lt) begin
        stored <= left_key;
      end else if (!lt) begin
        stored <= key;
      end
    end else if (ctrl.del) begin
      if (!lt) begin
        stored <= right_key;
      end
    end
  end

endmodule

FILE: rtl/core/sorted_array_set.sv
`timescale 1ns / 1ps
// flow: capture the request, compare it across the row of cells in ST_CMP, then in
//   ST_UPD, once the output can take it, shift the row by one step and register the result
// one item at a time: in_ready is high only in ST_IDLE, after the last item has committed
// reset: key count cleared to zero; the key store is not cleared and entries at or
//   above the count are masked out of the compares

module sorted_array_set #(
  parameter int CAPACITY  = sas_pkg::CAPACITY_DEFAULT,
  parameter int KEY_WIDTH = sas_pkg::KEY_WIDTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sas_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sas_pkg::rsp_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [sas_pkg::KIND_W-1:0]  req_kind;
  logic signed [KEY_WIDTH-1:0] req_key;
  logic [CW-1:0]               count;
  logic [CW-1:0]               count_next;

  logic signed [KEY_WIDTH-1:0] key_row [CAPACITY];
  logic [CAPACITY-1:0]         lt_row;
  logic [CAPACITY-1:0]         eq_row;
  logic [CW-1:0]               pos;
  logic                        present;
  logic                        full;
  logic                        commit;
  logic                        rejected;
  sas_pkg::shift_ctrl_t        ctrl;
  logic [63:0]                 key_ext;
  logic [63:0]                 pos_ext;
  logic [63:0]                 cnt_ext;

  assign in_ready = (state == ST_IDLE) && !rst;
  assign key_ext  = 64'($unsigned(in_data.key));

  // capture the request
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_kind <= in_data.kind;
      req_key  <= key_ext[KEY_WIDTH-1:0];
    end
  end

  // row of compare-and-shift cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KEY_WIDTH-1:0] left_key;
    logic signed [KEY_WIDTH-1:0] right_key;
    logic                        left_lt;

    if (i == 0) begin : g_first
      assign left_key = key_row[i];
      assign left_lt  = 1'b1;
    end else begin : g_mid
      assign left_key = key_row[i-1];
      assign left_lt  = lt_row[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_key = key_row[i];
    end else begin : g_inner
      assign right_key = key_row[i+1];
    end

    sas_cell #(
      .KEY_WIDTH   (KEY_WIDTH),
      .COUNT_WIDTH (CW),
      .INDEX       (i)
    ) u_cell (
      .clk       (clk),
      .cmp_en    (state == ST_CMP),
      .key       (req_key),
      .count     (count),
      .left_key  (left_key),
      .right_key (right_key),
      .left_lt   (left_lt),
      .ctrl      (ctrl),
      .stored    (key_row[i]),
      .lt        (lt_row[i]),
      .eq        (eq_row[i])
    );
  end

  // position from the edge of the less-than run
  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (lt_row[i] && ((i == CAPACITY - 1) || !lt_row[(i + 1) % CAPACITY])) begin
        pos = pos | CW'(i + 1);
      end
    end
  end

  assign present = |eq_row;
  assign full    = (count == CW'(CAPACITY));
  assign commit  = (state == ST_UPD) && (!out_valid || out_ready);

  // decide the action of this item
  always_comb begin
    ctrl       = '0;
    rejected   = 1'b0;
    count_next = count;
    if (commit) begin
      case (req_kind)
        sas_pkg::KIND_INSERT: begin
          if (!present) begin
            if (full) begin
              rejected = 1'b1;
            end else begin
              ctrl.ins   = 1'b1;
              count_next = count + 1'b1;
            end
          end
        end
        sas_pkg::KIND_DELETE: begin
          if (present) begin
            ctrl.del   = 1'b1;
            count_next = count - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_CMP;
      ST_CMP:  state_next = ST_UPD;
      ST_UPD:  if (commit) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // output register
  assign pos_ext = 64'(pos);
  assign cnt_ext = 64'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data.was_present   <= present;
      out_data.position      <= pos_ext[sas_pkg::FIELD_W-1:0];
      out_data.count_after   <= cnt_ext[sas_pkg::FIELD_W-1:0];
      out_data.rejected_full <= rejected;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("key count above capacity");

  a_lt_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) |-> ((lt_row & (lt_row + 1'b1)) == '0))
    else $error("less-than flags not a run from the bottom");

  a_eq_one: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) |-> $onehot0(eq_row))
    else $error("key matched in more than one cell");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !commit |=> (count == $past(count)))
    else $error("key count changed without a commit");

  a_reject_new: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.rejected_full && out_data.was_present))
    else $error("rejected insert reported a present key");

endmodule

FILE: test/tb_sorted_array_set.sv
`timescale 1ns / 1ps

module tb_sorted_array_set;

  localparam int CAP         = sas_pkg::CAPACITY_DEFAULT;
  localparam int RAND_ITEMS  = 1430;
  localparam int CALM_ITEMS  = 150;
  localparam int LONG_HOLD   = 300;
  localparam int HOLD_AT     = 400;
  localparam int SETTLE      = 16;
  localparam int CYCLE_LIMIT = 400000;

  // the unused request code, which the block treats as a query
  localparam logic [sas_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam logic signed [sas_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [sas_pkg::KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_NOISE} mix_t;

  typedef struct {
    sas_pkg::req_t req;
    bit            pinned;
    sas_pkg::rsp_t pinned_rsp;
  } plan_row_t;

  logic          clk;
  logic          rst       = 1'b1;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  sas_pkg::req_t in_data   = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  sas_pkg::rsp_t out_data;

  // mirror of the set contents, kept in ascending order
  logic signed [sas_pkg::KEY_W-1:0] mirror_keys [CAP];
  int                               mirror_count = 0;

  sas_pkg::rsp_t rsp_due [$];
  plan_row_t     plan [$];
  int            errors       = 0;
  int            results_seen = 0;
  int            cycle_count  = 0;
  bit            calm         = 1'b0;

  sorted_array_set uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // search the mirror, apply the request and return the result it gives
  function automatic sas_pkg::rsp_t lookup_and_update(input sas_pkg::req_t r);
    sas_pkg::rsp_t                    res;
    logic signed [sas_pkg::KEY_W-1:0] k;
    int                               pos;
    int                               i;
    bit                               hit;
    bit                               refused;
    k = r.key;
    pos = 0;
    refused = 1'b0;
    while (pos < mirror_count && mirror_keys[pos] < k) pos++;
    hit = (pos < mirror_count) && (mirror_keys[pos] == k);
    if (r.kind == sas_pkg::KIND_INSERT && !hit) begin
      if (mirror_count >= CAP) begin
        refused = 1'b1;
      end else begin
        for (i = mirror_count; i > pos; i--) mirror_keys[i] = mirror_keys[i-1];
        mirror_keys[pos] = k;
        mirror_count++;
      end
    end else if (r.kind == sas_pkg::KIND_DELETE && hit) begin
      for (i = pos; i + 1 < mirror_count; i++) mirror_keys[i] = mirror_keys[i+1];
      mirror_count--;
    end
    res.was_present   = hit;
    res.position      = sas_pkg::FIELD_W'(pos);
    res.count_after   = sas_pkg::FIELD_W'(mirror_count);
    res.rejected_full = refused;
    return res;
  endfunction

  function automatic logic [sas_pkg::KIND_W-1:0] pick_kind(input mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (r < 75) return sas_pkg::KIND_INSERT;
        if (r < 85) return sas_pkg::KIND_DELETE;
        return sas_pkg::KIND_QUERY;
      end
      MIX_DRAIN: begin
        if (r < 15) return sas_pkg::KIND_INSERT;
        if (r < 80) return sas_pkg::KIND_DELETE;
        return sas_pkg::KIND_QUERY;
      end
      MIX_BALANCED: begin
        if (r < 35) return sas_pkg::KIND_INSERT;
        if (r < 70) return sas_pkg::KIND_DELETE;
        if (r < 95) return sas_pkg::KIND_QUERY;
        return KIND_SPARE;
      end
      default: return sas_pkg::KIND_W'($urandom_range(0, 3));
    endcase
  endfunction

  // keys already held, a narrow band round zero, the extremes, or anything
  function automatic logic signed [sas_pkg::KEY_W-1:0] pick_key(input mix_t mix);
    int c;
    int v;
    c = $urandom_range(0, 99);
    if (mix == MIX_NOISE) c = (c < 70) ? 99 : c;
    if (c < 35 && mirror_count > 0) return mirror_keys[$urandom_range(0, mirror_count - 1)];
    if (c < 65) begin
      v = $urandom_range(0, 120);
      return v - 60;
    end
    if (c < 75) begin
      case ($urandom_range(0, 5))
        0: return KEY_MIN;
        1: return KEY_MAX;
        2: return KEY_MIN + 1;
        3: return KEY_MAX - 1;
        4: return 0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  task automatic pin(input logic [sas_pkg::KIND_W-1:0] kind,
                     input logic signed [sas_pkg::KEY_W-1:0] key,
                     input bit wp, input int pos, input int cnt, input bit rej);
    plan_row_t row;
    row.req.kind                 = kind;
    row.req.key                  = key;
    row.pinned                   = 1'b1;
    row.pinned_rsp.was_present   = wp;
    row.pinned_rsp.position      = sas_pkg::FIELD_W'(pos);
    row.pinned_rsp.count_after   = sas_pkg::FIELD_W'(cnt);
    row.pinned_rsp.rejected_full = rej;
    plan.push_back(row);
  endtask

  task automatic probe(input logic [sas_pkg::KIND_W-1:0] kind,
                       input logic signed [sas_pkg::KEY_W-1:0] key);
    plan_row_t row;
    row.req.kind   = kind;
    row.req.key    = key;
    row.pinned     = 1'b0;
    row.pinned_rsp = '0;
    plan.push_back(row);
  endtask

  // offer one request and hold it until the transfer
  task automatic send(input sas_pkg::req_t r, input bit pinned,
                      input sas_pkg::rsp_t pinned_rsp);
    sas_pkg::rsp_t model_rsp;
    in_data  <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    model_rsp = lookup_and_update(r);
    rsp_due.push_back(pinned ? pinned_rsp : model_rsp);
  endtask

  task automatic idle_for(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // stop offering until every outstanding result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // stimulus
  initial begin : stimulus
    mix_t          mix;
    int            phase_left;
    int            sent;
    bit            idle_on;
    bit            paused_once;
    sas_pkg::req_t item;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed rows: empty set, extremes, duplicates, absent deletes, spare code
    pin(sas_pkg::KIND_QUERY,  KEY_MAX, 0, 0, 0, 0);
    pin(sas_pkg::KIND_DELETE, KEY_MIN, 0, 0, 0, 0);
    pin(KIND_SPARE,           0,       0, 0, 0, 0);
    pin(sas_pkg::KIND_INSERT, KEY_MIN, 0, 0, 1, 0);
    pin(sas_pkg::KIND_INSERT, KEY_MAX, 0, 1, 2, 0);
    pin(sas_pkg::KIND_INSERT, KEY_MIN, 1, 0, 2, 0);
    pin(sas_pkg::KIND_QUERY,  KEY_MAX, 1, 1, 2, 0);
    pin(KIND_SPARE,           KEY_MAX, 1, 1, 2, 0);
    pin(sas_pkg::KIND_INSERT, 0,       0, 1, 3, 0);
    pin(sas_pkg::KIND_INSERT, -1,      0, 1, 4, 0);
    pin(sas_pkg::KIND_INSERT, 1,       0, 3, 5, 0);
    probe(sas_pkg::KIND_QUERY, KEY_MIN + 1);
    probe(sas_pkg::KIND_QUERY, KEY_MAX - 1);
    pin(sas_pkg::KIND_DELETE, 0,       1, 2, 4, 0);
    pin(sas_pkg::KIND_DELETE, 0,       0, 2, 4, 0);
    pin(sas_pkg::KIND_DELETE, KEY_MAX, 1, 3, 3, 0);
    pin(sas_pkg::KIND_DELETE, KEY_MIN, 1, 0, 2, 0);
    probe(sas_pkg::KIND_INSERT, 32'sh5555_5555);
    probe(sas_pkg::KIND_INSERT, 32'shaaaa_aaaa);
    probe(sas_pkg::KIND_QUERY,  32'sh5555_5555);
    probe(KIND_SPARE,           32'shaaaa_aaaa);
    probe(sas_pkg::KIND_DELETE, 32'sh5555_5555);

    foreach (plan[i]) begin
      send(plan[i].req, plan[i].pinned, plan[i].pinned_rsp);
      if ($urandom_range(0, 2) == 0) idle_for($urandom_range(1, 16));
    end
    wait_drained();

    // random phases; the first one is mostly inserts and aims to fill the store to capacity
    sent        = 0;
    phase_left  = 0;
    paused_once = 1'b0;
    mix         = MIX_FILL;
    idle_on     = 1'b1;
    while (sent < RAND_ITEMS) begin
      if (phase_left == 0) begin
        phase_left = (sent == 0) ? 250 : $urandom_range(60, 160);
        if (sent != 0) mix = mix_t'($urandom_range(0, 3));
        idle_on = ($urandom_range(0, 2) != 0);
      end
      if (!paused_once && sent >= RAND_ITEMS / 2) begin
        paused_once = 1'b1;
        wait_drained();
      end
      if (sent >= RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
      item.kind = pick_kind(mix);
      item.key  = pick_key(mix);
      send(item, 1'b0, '0);
      sent++;
      phase_left--;
      if (!calm && idle_on && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 16));
    end
    in_valid <= 1'b0;

    // let the last results come back, then allow for stragglers
    while (rsp_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // result side: check each transfer and vary ready
  initial begin : sink
    int            left;
    bit            long_done;
    sas_pkg::rsp_t want;
    left      = 0;
    long_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        results_seen++;
        if (rsp_due.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none, actual %p", $time, out_data);
        end else begin
          want = rsp_due.pop_front();
          check_field("was_present",   want.was_present,   out_data.was_present);
          check_field("position",      want.position,      out_data.position);
          check_field("count_after",   want.count_after,   out_data.count_after);
          check_field("rejected_full", want.rejected_full, out_data.rejected_full);
        end
      end
      // long hold-off so the block backs up and stalls its input
      if (!long_done && results_seen == HOLD_AT) begin
        long_done = 1'b1;
        out_ready <= 1'b0;
        left = LONG_HOLD;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else if (left > 0) begin
        left--;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        left = $urandom_range(1, 16) - 1;
      end else begin
        out_ready <= 1'b1;
        left = $urandom_range(0, 20);
      end
    end
  end

  // watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/sas_pkg.sv
rtl/core/sas_cell.sv
rtl/core/sorted_array_set.sv
test/tb_sorted_array_set.sv
